FILE: hw/rtl/bfkp_pkg.sv
// Package for the byte queue with key purge: sizes, command codes and item types.
`default_nettype none

package bfkp_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Command codes
  localparam logic [1:0] CmdPush  = 2'd0;
  localparam logic [1:0] CmdPop   = 2'd1;
  localparam logic [1:0] CmdPurge = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  // Input item
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] popped_byte;
    logic       popped_valid;
    logic       overflow;
    logic [6:0] purged_count;
    logic [6:0] occupancy;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/byte_fifo_with_key_purge.sv
// Bounded byte queue with push, pop, purge-by-key and clear, one result per item.
// Push and clear go to StFin; pop reads the head byte in StPop; purge of a queue holding
// n bytes walks them in StPurge (one stored byte per cycle through the single read port).
// A new item is taken in the cycle after the result has moved into the output register.
// Reset (async, active low) empties the queue and drops any pending result; the byte store
// is not cleared and needs no clearing pass.
`default_nettype none

module byte_fifo_with_key_purge (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bfkp_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bfkp_pkg::out_t      out_data_o
);
  import bfkp_pkg::*;

  // Sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPop   = 2'd1;
  localparam logic [1:0] StPurge = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] iss_q, iss_d, chk_q, chk_d;
  logic [CntW-1:0] purged_q, purged_d;
  logic            rvld_q, rvld_d;
  logic [7:0]      key_q, key_d;
  out_t            res_q, res_d;
  out_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;

  // Byte store, one write and one registered read port
  logic [7:0]      mem_q [QueueDepth];
  logic [7:0]      rdata_q;
  logic            we;
  logic [PtrW-1:0] waddr, raddr;
  logic [7:0]      wdata;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    next_slot = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Sequencer and result building
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    purged_d  = purged_q;
    rvld_d    = 1'b0;
    key_d     = key_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    we        = 1'b0;
    waddr     = tail_q;
    wdata     = in_data_i.data;
    raddr     = head_q;
    in_ready_o = (state_q == StIdle);

    // result leaves the output register
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          key_d = in_data_i.data;
          res_d = '0;
          case (in_data_i.command)
            CmdPush: begin
              if (count_q == CntW'(QueueDepth)) begin
                res_d.overflow = 1'b1;
              end else begin
                we      = 1'b1;
                tail_d  = next_slot(tail_q);
                count_d = count_q + CntW'(1);
              end
              res_d.occupancy = 7'(count_d);
              state_d = StFin;
            end
            CmdPop: begin
              // head byte is read at this edge
              res_d.occupancy = 7'(count_q);
              state_d = (count_q == '0) ? StFin : StPop;
            end
            CmdPurge: begin
              rd_d     = head_q;
              wr_d     = head_q;
              iss_d    = count_q;
              chk_d    = count_q;
              purged_d = '0;
              state_d  = StPurge;
            end
            default: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              state_d = StFin;
            end
          endcase
        end
      end
      StPop: begin
        res_d.popped_byte  = rdata_q;
        res_d.popped_valid = 1'b1;
        head_d             = next_slot(head_q);
        count_d            = count_q - CntW'(1);
        res_d.occupancy    = 7'(count_d);
        state_d            = StFin;
      end
      StPurge: begin
        // issue the next read
        if (iss_q != '0) begin
          raddr  = rd_q;
          rd_d   = next_slot(rd_q);
          iss_d  = iss_q - CntW'(1);
          rvld_d = 1'b1;
        end
        // check the byte read last cycle; survivors are packed toward the head
        if (rvld_q) begin
          chk_d = chk_q - CntW'(1);
          if (rdata_q == key_q) begin
            purged_d = purged_q + CntW'(1);
          end else begin
            we    = 1'b1;
            waddr = wr_q;
            wdata = rdata_q;
            wr_d  = next_slot(wr_q);
          end
        end
        if ((chk_q == '0) || (rvld_q && (chk_q == CntW'(1)))) begin
          tail_d             = wr_d;
          count_d            = count_q - purged_d;
          res_d.purged_count = 7'(purged_d);
          res_d.occupancy    = 7'(count_d);
          state_d            = StFin;
        end
      end
      StFin: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      iss_q     <= '0;
      chk_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      iss_q     <= iss_d;
      chk_q     <= chk_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    wr_q     <= wr_d;
    purged_q <= purged_d;
    key_q    <= key_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count above depth");

  a_ptr_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ((tail_q - head_q) == count_q[PtrW-1:0]))
    else $error("head, tail and count disagree");

  a_walk_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPurge) |-> (chk_q == (iss_q + CntW'(rvld_q))))
    else $error("purge read and check counters out of step");

  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.popped_valid) |-> (!out_q.overflow && (out_q.purged_count == '0)))
    else $error("pop result carries push or purge status");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != StIdle))
    else $error("accepted item did not start the sequencer");
`endif

endmodule

`default_nettype wire
